// ===== sv/kst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_pkg
// Shared constants and types for the k-secretary top-k selector.
// ----------------------------------------------------------------------------
package kst_pkg;

  // parameter defaults
  localparam int MAX_K_DEF     = 64;
  localparam int RANK_BITS_DEF = 10;

  // fixed field widths
  localparam int RANK_W     = 11;
  localparam int TOTAL_W    = 11;
  localparam int SELECT_W   = 7;
  localparam int SAMPLE_W   = 10;
  localparam int COUNT_W    = 7;
  localparam int KEFF_W     = 9;   // holds MAX_K up to 256
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_ITEMS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SELECT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SIZE  = 2'd2;

  // configuration reset values
  localparam logic [TOTAL_W-1:0]  TOTAL_ITEMS_RST  = 11'd100;
  localparam logic [SELECT_W-1:0] SELECT_COUNT_RST = 7'd1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_SIZE_RST  = 10'd37;

  // broadcast control to every list cell
  typedef struct packed {
    logic clr;  // trial start: entries read as zero
    logic ins;  // insertion allowed for this transaction
  } cell_ctrl_t;

endpackage

// ===== sv/kst_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_in_if / kst_out_if
// Valid/ready channels for candidate items and per-item results.
// ----------------------------------------------------------------------------
interface kst_in_if;
  import kst_pkg::*;
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank_value;
  logic              trial_start;

  modport source (output valid, output rank_value, output trial_start, input ready);
  modport sink   (input valid, input rank_value, input trial_start, output ready);
endinterface

interface kst_out_if;
  import kst_pkg::*;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               top_hit;
  logic [COUNT_W-1:0] accept_total;
  logic [COUNT_W-1:0] score;
  logic               trial_over;

  modport source (output valid, output accepted, output top_hit, output accept_total,
                  output score, output trial_over, input ready);
  modport sink   (input valid, input accepted, input top_hit, input accept_total,
                  input score, input trial_over, output ready);
endinterface

// ===== sv/k_secretary_topk_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_secretary_topk_selector
// Multiple-secretary threshold selection over one trial of ranks, with the
// k best ranks held in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_i      in   valid/ready        rank_value, trial_start
//  res_o     out  valid/ready        accepted, top_hit, accept_total, score,
//                                    trial_over
//  cfg       in   cfg_we_i (no wait) cfg_idx_i, cfg_data_i
//
// One transaction per cycle unless a full output register is stalled: all
// cells compare against the rank in parallel, the OR of their take flags and
// the counter update close the cycle. Result appears in an output register in
// the cycle after acceptance; input is taken while it is empty or being
// drained. No clearing pass: reset zeroes the list and counters directly.
// ----------------------------------------------------------------------------
module k_secretary_topk_selector
  import kst_pkg::*;
#(
  parameter int MaxK     = MAX_K_DEF,
  parameter int RankBits = RANK_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  kst_in_if.sink                in_i,
  kst_out_if.source             res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int EntryW = RankBits + 1;
  localparam int HitW   = ((EntryW > TOTAL_W) ? EntryW : TOTAL_W) + 2;
  localparam logic [KEFF_W-1:0] MaxKK = KEFF_W'(MaxK);

  // configuration
  logic [TOTAL_W-1:0]  total_q;
  logic [SELECT_W-1:0] select_q;
  logic [SAMPLE_W-1:0] sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= TOTAL_ITEMS_RST;
      select_q <= SELECT_COUNT_RST;
      sample_q <= SAMPLE_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TOTAL_ITEMS:  total_q  <= cfg_data_i[TOTAL_W-1:0];
        REG_SELECT_COUNT: select_q <= cfg_data_i[SELECT_W-1:0];
        REG_SAMPLE_SIZE:  sample_q <= cfg_data_i[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [KEFF_W-1:0] k_eff;
  assign k_eff = ({2'b00, select_q} > MaxKK) ? MaxKK : {2'b00, select_q};

  // handshake
  logic out_valid_q;
  logic fire;

  assign in_i.ready = !out_valid_q || res_o.ready;
  assign fire       = in_i.valid && in_i.ready;

  // trial state
  logic [TOTAL_W-1:0] item_q, item_c, item_d;
  logic [COUNT_W-1:0] acc_q, acc_c, acc_d;
  logic [COUNT_W-1:0] hit_q, hit_c, hit_d;
  logic               st;
  logic [EntryW-1:0]  rank;
  logic               active, observe, can_sel, inserted, acc, hit;
  cell_ctrl_t         ctrl;

  assign st     = in_i.trial_start;
  assign rank   = EntryW'(in_i.rank_value);
  assign item_c = st ? '0 : item_q;
  assign acc_c  = st ? '0 : acc_q;
  assign hit_c  = st ? '0 : hit_q;

  assign active  = (item_c < total_q);
  assign observe = ({1'b0, item_c} < {2'b00, sample_q});
  assign can_sel = ({2'b00, acc_c} < k_eff);

  assign ctrl.clr = st;
  assign ctrl.ins = active && (observe || can_sel);

  // cell chain
  logic [EntryW-1:0] entry_w [MaxK];
  logic [MaxK-1:0]   ge_w;
  logic [MaxK-1:0]   take_w;

  for (genvar i = 0; i < MaxK; i++) begin : g_cell
    logic [EntryW-1:0] prev_entry;
    logic              prev_ge;
    if (i == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_ge    = 1'b1;
    end else begin : g_link
      assign prev_entry = entry_w[i-1];
      assign prev_ge    = ge_w[i-1];
    end
    kst_cell #(
      .EntryW (EntryW),
      .Idx    (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .load_i       (fire),
      .ctrl_i       (ctrl),
      .rank_i       (rank),
      .k_i          (k_eff),
      .prev_entry_i (prev_entry),
      .prev_ge_i    (prev_ge),
      .entry_o      (entry_w[i]),
      .ge_o         (ge_w[i]),
      .take_o       (take_w[i])
    );
  end

  // rank enters the list iff the last in-range cell holds a smaller entry
  assign inserted = |take_w;
  assign acc      = active && !observe && can_sel && inserted;
  // rank > n - k, done without going negative
  assign hit      = acc && ((HitW'(rank) + HitW'(k_eff)) > HitW'(total_q));

  assign item_d = active ? item_c + 1'b1 : item_c;
  assign acc_d  = acc_c + COUNT_W'(acc);
  assign hit_d  = hit_c + COUNT_W'(hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
      acc_q  <= '0;
      hit_q  <= '0;
    end else if (fire) begin
      item_q <= item_d;
      acc_q  <= acc_d;
      hit_q  <= hit_d;
    end
  end

  // result register
  logic               r_acc_q, r_hit_q, r_over_q;
  logic [COUNT_W-1:0] r_total_q, r_score_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      r_acc_q   <= acc;
      r_hit_q   <= hit;
      r_total_q <= acc_d;
      r_score_q <= hit_d;
      r_over_q  <= ({2'b00, acc_d} >= k_eff) || (item_d >= total_q);
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.accepted     = r_acc_q;
  assign res_o.top_hit      = r_hit_q;
  assign res_o.accept_total = r_total_q;
  assign res_o.score        = r_score_q;
  assign res_o.trial_over   = r_over_q;

endmodule

// ===== sv/kst_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_cell
// One entry of the descending best list. Compares its entry with the
// broadcast rank and shifts in its left neighbor's entry on insertion.
// ----------------------------------------------------------------------------
module kst_cell
  import kst_pkg::*;
#(
  parameter int EntryW = RANK_BITS_DEF + 1,
  parameter int Idx    = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [EntryW-1:0] rank_i,
  input  logic [KEFF_W-1:0] k_i,
  input  logic [EntryW-1:0] prev_entry_i,
  input  logic              prev_ge_i,
  output logic [EntryW-1:0] entry_o,
  output logic              ge_o,
  output logic              take_o
);

  localparam logic [KEFF_W-1:0] IdxK = KEFF_W'(Idx);

  logic [EntryW-1:0] entry_q, entry_d;
  logic              in_range;

  assign entry_o  = ctrl_i.clr ? '0 : entry_q;
  assign ge_o     = (entry_o >= rank_i);
  assign in_range = (IdxK < k_i);
  assign take_o   = in_range && !ge_o;

  // first taking cell gets the rank, the rest shift right by one
  always_comb begin
    entry_d = entry_o;
    if (ctrl_i.ins && take_o) begin
      entry_d = prev_ge_i ? rank_i : prev_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (load_i) begin
      entry_q <= entry_d;
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k-secretary top-k selector. Trials of shuffled
// ranks with some noise run under many register settings. A tracker class
// models the list and counters, and each result is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import kst_pkg::*;

  localparam int ITEM_TARGET = 1050;

  typedef struct packed {
    logic               accepted;
    logic               top_hit;
    logic [COUNT_W-1:0] accept_total;
    logic [COUNT_W-1:0] score;
    logic               trial_over;
  } verdict_t;

  // Keeps its own copy of the k-best list and counters, predicts one
  // verdict per accepted candidate and checks results in order.
  class secretary_tracker;
    logic [RANK_W-1:0]   best_ranks[MAX_K_DEF];
    logic [TOTAL_W-1:0]  total_items;
    logic [SELECT_W-1:0] select_count;
    logic [SAMPLE_W-1:0] sample_size;
    logic [TOTAL_W-1:0]  item_idx;
    logic [COUNT_W-1:0]  acc_cnt;
    logic [COUNT_W-1:0]  hit_cnt;
    verdict_t            pending[$];
    int                  mismatches;
    int                  accepts_total;
    int                  hits_total;

    function new();
      total_items   = TOTAL_ITEMS_RST;
      select_count  = SELECT_COUNT_RST;
      sample_size   = SAMPLE_SIZE_RST;
      mismatches    = 0;
      accepts_total = 0;
      hits_total    = 0;
      clear_trial();
    endfunction

    function void clear_trial();
      foreach (best_ranks[i]) best_ranks[i] = '0;
      item_idx = '0;
      acc_cnt  = '0;
      hit_cnt  = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TOTAL_ITEMS:  total_items  = data[TOTAL_W-1:0];
        REG_SELECT_COUNT: select_count = data[SELECT_W-1:0];
        REG_SAMPLE_SIZE:  sample_size  = data[SAMPLE_W-1:0];
        default: ;
      endcase
    endfunction

    // equal ranks go behind existing ones; entry needs a strictly larger rank
    function bit place_rank(logic [RANK_W-1:0] rank, int k);
      int pos;
      pos = 0;
      while (pos < k && best_ranks[pos] >= rank) pos++;
      if (pos >= k) return 1'b0;
      for (int j = k - 1; j > pos; j--) best_ranks[j] = best_ranks[j-1];
      best_ranks[pos] = rank;
      return 1'b1;
    endfunction

    function void take_candidate(logic [RANK_W-1:0] rank, logic start);
      verdict_t v;
      int       k;
      k = (int'(select_count) > MAX_K_DEF) ? MAX_K_DEF : int'(select_count);
      v = '0;
      if (start) clear_trial();
      if (item_idx < total_items) begin
        if (item_idx < sample_size) begin
          void'(place_rank(rank, k));
        end else if (int'(acc_cnt) < k && place_rank(rank, k)) begin
          v.accepted = 1'b1;
          acc_cnt++;
          accepts_total++;
          // threshold may go negative when k > n
          if (int'(rank) > int'(total_items) - k) begin
            v.top_hit = 1'b1;
            hit_cnt++;
            hits_total++;
          end
        end
        item_idx++;
      end
      v.accept_total = acc_cnt;
      v.score        = hit_cnt;
      v.trial_over   = (int'(acc_cnt) >= k) || (item_idx >= total_items);
      pending.push_back(v);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        $error("result arrived with no prediction pending");
        mismatches++;
        return;
      end
      want = pending.pop_front();
      compare_field("accepted", 8'(want.accepted), 8'(got.accepted));
      compare_field("top_hit", 8'(want.top_hit), 8'(got.top_hit));
      compare_field("accept_total", 8'(want.accept_total), 8'(got.accept_total));
      compare_field("score", 8'(want.score), 8'(got.score));
      compare_field("trial_over", 8'(want.trial_over), 8'(got.trial_over));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit               no_idle = 1'b0;
  int               items_sent = 0;
  int               settings_run = 0;
  int               trials_run = 0;
  secretary_tracker tracker;

  kst_in_if  in_if ();
  kst_out_if res_if ();

  k_secretary_topk_selector uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  // valid stays high between back-to-back transactions
  task automatic send_item(input logic [RANK_W-1:0] rank, input logic start);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.rank_value  <= rank;
    in_if.trial_start <= start;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    tracker.take_candidate(rank, start);
    items_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic reprogram(input int n, input int k, input int s);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_TOTAL_ITEMS;
    cfg_data <= CFG_DATA_W'(n);
    @(posedge clk);
    tracker.write_reg(REG_TOTAL_ITEMS, CFG_DATA_W'(n));
    cfg_idx  <= REG_SELECT_COUNT;
    cfg_data <= CFG_DATA_W'(k);
    @(posedge clk);
    tracker.write_reg(REG_SELECT_COUNT, CFG_DATA_W'(k));
    cfg_idx  <= REG_SAMPLE_SIZE;
    cfg_data <= CFG_DATA_W'(s);
    @(posedge clk);
    tracker.write_reg(REG_SAMPLE_SIZE, CFG_DATA_W'(s));
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // one trial: a shuffled 1..n, occasional noise ranks, a few items past n (for
  // n > 120 only 20 to 90 items), and now and then a trial start in the middle
  task automatic run_trial(input int n, output int sent);
    logic [RANK_W-1:0] order[$];
    logic [RANK_W-1:0] tmp;
    logic [RANK_W-1:0] rank;
    logic              start;
    int                len;
    int                r;
    order = {};
    for (int v = 1; v <= n; v++) order.push_back(RANK_W'(v));
    for (int a = n - 1; a > 0; a--) begin
      r        = $urandom_range(0, a);
      tmp      = order[a];
      order[a] = order[r];
      order[r] = tmp;
    end
    if (n == 0) len = 3;
    else if (n <= 120) len = n + $urandom_range(0, 2);
    else len = $urandom_range(20, 90);
    for (int i = 0; i < len; i++) begin
      rank  = (i < n) ? order[i] : RANK_W'($urandom_range(0, 2047));
      if ($urandom_range(0, 11) == 0) rank = RANK_W'($urandom_range(0, 2047));
      start = (i == 0) || ($urandom_range(0, 149) == 0);
      send_item(rank, start);
    end
    trials_run++;
    sent = len;
  endtask

  task automatic random_phase(input int phase);
    int n;
    int k;
    int s;
    int kmax;
    int base;
    int phase_items;
    int sent;
    case ($urandom_range(0, 15))
      0:       n = 2;
      1:       n = 1024;
      2:       n = 2047;
      3:       n = 0;
      4, 5, 6, 7, 8: n = $urandom_range(3, 20);
      default: n = $urandom_range(21, 120);
    endcase
    kmax = n / 2;
    if (kmax < 1) kmax = 1;
    if (kmax > 64) kmax = 64;
    case ($urandom_range(0, 9))
      0:       k = 1;
      1:       k = 64;
      2:       k = 0;
      3:       k = $urandom_range(65, 127);
      default: k = $urandom_range(1, kmax);
    endcase
    base = (n > 120) ? 60 : n;
    s = base * $urandom_range(10, 50) / 100;
    if (s < 1) s = 1;
    case ($urandom_range(0, 11))
      0:       s = 1;
      1:       s = 1023;
      2:       s = (n > 1023) ? 1023 : n;
      3:       s = 0;
      default: ;
    endcase
    // the first few settings pin the register extremes
    case (phase)
      0: begin n = 64;   k = 64; s = 8;    end
      1: begin n = 1024; k = 1;  s = 1023; end
      2: begin n = 2;    k = 1;  s = 1;    end
      default: ;
    endcase
    reprogram(n, k, s);
    no_idle = ($urandom_range(0, 3) == 0);
    phase_items = 0;
    while (phase_items < 100 && items_sent < ITEM_TARGET) begin
      run_trial(n, sent);
      phase_items += sent;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int phase;
    tracker          = new();
    in_if.valid       <= 1'b0;
    in_if.rank_value  <= '0;
    in_if.trial_start <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= REG_TOTAL_ITEMS;
    cfg_data          <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // small trial: repeated rank, rank zero, items past n
    reprogram(8, 3, 2);
    send_item(11'd5, 1'b1);
    send_item(11'd2, 1'b0);
    send_item(11'd7, 1'b0);
    send_item(11'd7, 1'b0);
    send_item(11'd0, 1'b0);
    send_item(11'd8, 1'b0);
    send_item(11'd1, 1'b0);
    send_item(11'd6, 1'b0);
    send_item(11'd4, 1'b0);
    send_item(11'd3, 1'b0);
    // widest ranks
    send_item(11'd1024, 1'b1);
    send_item(11'd2047, 1'b0);
    send_item(11'd1, 1'b0);
    // k above the list size, so n - k is negative
    reprogram(3, 100, 1);
    send_item(11'd1, 1'b1);
    send_item(11'd3, 1'b0);
    send_item(11'd2, 1'b0);
    // k of zero
    reprogram(10, 0, 1);
    send_item(11'd4, 1'b1);
    send_item(11'd9, 1'b0);
    // observation covers the whole trial
    reprogram(4, 5, 1023);
    send_item(11'd2, 1'b1);
    send_item(11'd1, 1'b0);
    send_item(11'd4, 1'b0);
    send_item(11'd3, 1'b0);
    send_item(11'd2, 1'b0);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      random_phase(phase);
      phase++;
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d candidates in %0d trials under %0d register settings;",
             items_sent, trials_run, settings_run);
    $display("%0d were accepted, %0d of those among the true top k.",
             tracker.accepts_total, tracker.hits_total);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result side: random stalls, each accepted transaction checked in order
  initial begin
    int       gap;
    verdict_t got;
    res_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      got.accepted     = res_if.accepted;
      got.top_hit      = res_if.top_hit;
      got.accept_total = res_if.accept_total;
      got.score        = res_if.score;
      got.trial_over   = res_if.trial_over;
      tracker.check_verdict(got);
    end
  end

endmodule
